// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants and types for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FUNC_BITS     = 3;

    localparam logic [FUNC_BITS-1:0] FN_ADD = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_SUB = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_MUL = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_DIV = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_EQ  = 3'd4;
    localparam logic [FUNC_BITS-1:0] FN_NE  = 3'd5;

    typedef struct packed {
        logic is_div;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic cmp;
        logic sat;
    } cau_ctrl_t;

endpackage

// ===== src/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Products, sums and normalization ahead of the divider chain (3 stages).
// ----------------------------------------------------------------------------
module cau_front #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
    parameter int NB        = 2 * WORD_BITS + 1 + FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cau_pkg::FUNC_BITS-1:0] func,
    input  logic signed [WORD_BITS-1:0]   a_re,
    input  logic signed [WORD_BITS-1:0]   a_im,
    input  logic signed [WORD_BITS-1:0]   b_re,
    input  logic signed [WORD_BITS-1:0]   b_im,
    output logic                          out_valid,
    output cau_pkg::cau_ctrl_t            out_ctrl,
    output logic [2*WORD_BITS-1:0]        out_den,
    output logic [NB-1:0]                 out_x_re,
    output logic [NB-1:0]                 out_x_im
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    // stage 1
    logic                          v1_reg;
    logic [cau_pkg::FUNC_BITS-1:0] func1_reg;
    logic signed [PW-1:0]          prr1_reg, pii1_reg, pri1_reg, pir1_reg, pbb1_reg, pcc1_reg;
    logic [W-1:0]                  asr1_reg, asi1_reg;
    logic                          asat1_reg, cmp1_reg;

    logic signed [W:0] sum_re, sum_im;
    logic              is_as, ovf_re, ovf_im, eq;
    logic [W-1:0]      asr_next, asi_next;
    logic              asat_next, cmp_next;

    always_comb
    begin
        is_as = (func == cau_pkg::FN_ADD) || (func == cau_pkg::FN_SUB);
        if (func == cau_pkg::FN_SUB)
        begin
            sum_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
            sum_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
        end
        else
        begin
            sum_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
            sum_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
        end
        ovf_re = sum_re[W] ^ sum_re[W-1];
        ovf_im = sum_im[W] ^ sum_im[W-1];
        asr_next = '0;
        asi_next = '0;
        asat_next = 1'b0;
        if (is_as)
        begin
            asr_next = ovf_re ? (sum_re[W] ? MINW : MAXW) : sum_re[W-1:0];
            asi_next = ovf_im ? (sum_im[W] ? MINW : MAXW) : sum_im[W-1:0];
            asat_next = ovf_re | ovf_im;
        end
        eq = (a_re == b_re) && (a_im == b_im);
        cmp_next = (func == cau_pkg::FN_EQ) ? eq : ((func == cau_pkg::FN_NE) ? !eq : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func;
            prr1_reg  <= a_re * b_re;
            pii1_reg  <= a_im * b_im;
            pri1_reg  <= a_re * b_im;
            pir1_reg  <= a_im * b_re;
            pbb1_reg  <= b_re * b_re;
            pcc1_reg  <= b_im * b_im;
            asr1_reg  <= asr_next;
            asi1_reg  <= asi_next;
            asat1_reg <= asat_next;
            cmp1_reg  <= cmp_next;
        end
    end

    // stage 2
    logic                          v2_reg;
    logic [cau_pkg::FUNC_BITS-1:0] func2_reg;
    logic signed [PW:0]            mre2_reg, mim2_reg, nre2_reg, nim2_reg;
    logic [PW-1:0]                 den2_reg;
    logic [W-1:0]                  asr2_reg, asi2_reg;
    logic                          asat2_reg, cmp2_reg;

    logic signed [PW:0] xrr, xii, xri, xir;
    logic [PW-1:0]      den_sum;

    always_comb
    begin
        xrr = {prr1_reg[PW-1], prr1_reg};
        xii = {pii1_reg[PW-1], pii1_reg};
        xri = {pri1_reg[PW-1], pri1_reg};
        xir = {pir1_reg[PW-1], pir1_reg};
        den_sum = pbb1_reg + pcc1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func2_reg <= func1_reg;
            mre2_reg  <= xrr - xii;
            mim2_reg  <= xri + xir;
            nre2_reg  <= xrr + xii;
            nim2_reg  <= xir - xri;
            den2_reg  <= den_sum;
            asr2_reg  <= asr1_reg;
            asi2_reg  <= asi1_reg;
            asat2_reg <= asat1_reg;
            cmp2_reg  <= cmp1_reg;
        end
    end

    // stage 3
    logic                 v3_reg;
    cau_pkg::cau_ctrl_t   ctrl3_reg, ctrl_next;
    logic [PW-1:0]        den3_reg;
    logic [NB-1:0]        xre3_reg, xim3_reg, xre_next, xim_next;

    logic signed [PW:0]   sh_re, sh_im;
    logic [PW-W+1:0]      hi_re, hi_im;
    logic                 movf_re, movf_im, is_mul, is_div;
    logic [W-1:0]         mr, mi;
    logic [PW:0]          mag_re, mag_im;

    always_comb
    begin
        is_mul = (func2_reg == cau_pkg::FN_MUL);
        is_div = (func2_reg == cau_pkg::FN_DIV);
        sh_re = mre2_reg >>> FRAC_BITS;
        sh_im = mim2_reg >>> FRAC_BITS;
        hi_re = sh_re[PW:W-1];
        hi_im = sh_im[PW:W-1];
        movf_re = !((&hi_re) || !(|hi_re));
        movf_im = !((&hi_im) || !(|hi_im));
        mr = movf_re ? (sh_re[PW] ? MINW : MAXW) : sh_re[W-1:0];
        mi = movf_im ? (sh_im[PW] ? MINW : MAXW) : sh_im[W-1:0];
        mag_re = nre2_reg[PW] ? (-nre2_reg) : nre2_reg;
        mag_im = nim2_reg[PW] ? (-nim2_reg) : nim2_reg;

        ctrl_next.is_div = is_div;
        ctrl_next.dz     = is_div && (den2_reg == '0);
        ctrl_next.neg_re = nre2_reg[PW];
        ctrl_next.neg_im = nim2_reg[PW];
        ctrl_next.cmp    = cmp2_reg;
        ctrl_next.sat    = asat2_reg | (is_mul & (movf_re | movf_im));

        if (is_div)
        begin
            xre_next = NB'(mag_re) << FRAC_BITS;
            xim_next = NB'(mag_im) << FRAC_BITS;
        end
        else if (is_mul)
        begin
            xre_next = {{(NB-W){1'b0}}, mr};
            xim_next = {{(NB-W){1'b0}}, mi};
        end
        else
        begin
            xre_next = {{(NB-W){1'b0}}, asr2_reg};
            xim_next = {{(NB-W){1'b0}}, asi2_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl3_reg <= ctrl_next;
            den3_reg  <= den2_reg;
            xre3_reg  <= xre_next;
            xim3_reg  <= xim_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_ctrl  = ctrl3_reg;
    assign out_den   = den3_reg;
    assign out_x_re  = xre3_reg;
    assign out_x_im  = xim3_reg;

endmodule

// ===== src/cau_div_cell.sv =====
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step for both result parts; passes other items on.
// ----------------------------------------------------------------------------
module cau_div_cell #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int NB        = 2 * WORD_BITS + 1 + cau_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  cau_pkg::cau_ctrl_t     in_ctrl,
    input  logic [2*WORD_BITS-1:0] in_den,
    input  logic [2*WORD_BITS-1:0] in_rem_re,
    input  logic [2*WORD_BITS-1:0] in_rem_im,
    input  logic [NB-1:0]          in_x_re,
    input  logic [NB-1:0]          in_x_im,
    output logic                   out_valid,
    output cau_pkg::cau_ctrl_t     out_ctrl,
    output logic [2*WORD_BITS-1:0] out_den,
    output logic [2*WORD_BITS-1:0] out_rem_re,
    output logic [2*WORD_BITS-1:0] out_rem_im,
    output logic [NB-1:0]          out_x_re,
    output logic [NB-1:0]          out_x_im
);

    localparam int PW = 2 * WORD_BITS;

    logic                 valid_reg;
    cau_pkg::cau_ctrl_t   ctrl_reg;
    logic [PW-1:0]        den_reg, rem_re_reg, rem_im_reg, rem_re_next, rem_im_next;
    logic [NB-1:0]        x_re_reg, x_im_reg, x_re_next, x_im_next;
    logic [PW:0]          r_re, r_im, d_ext, s_re, s_im;
    logic                 ge_re, ge_im;

    always_comb
    begin
        d_ext = {1'b0, in_den};
        r_re = {in_rem_re, in_x_re[NB-1]};
        r_im = {in_rem_im, in_x_im[NB-1]};
        ge_re = r_re >= d_ext;
        ge_im = r_im >= d_ext;
        s_re = ge_re ? (r_re - d_ext) : r_re;
        s_im = ge_im ? (r_im - d_ext) : r_im;
        if (in_ctrl.is_div)
        begin
            rem_re_next = s_re[PW-1:0];
            rem_im_next = s_im[PW-1:0];
            x_re_next = {in_x_re[NB-2:0], ge_re};
            x_im_next = {in_x_im[NB-2:0], ge_im};
        end
        else
        begin
            rem_re_next = in_rem_re;
            rem_im_next = in_rem_im;
            x_re_next = in_x_re;
            x_im_next = in_x_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctrl_reg   <= in_ctrl;
            den_reg    <= in_den;
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            x_re_reg   <= x_re_next;
            x_im_reg   <= x_im_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_ctrl   = ctrl_reg;
    assign out_den    = den_reg;
    assign out_rem_re = rem_re_reg;
    assign out_rem_im = rem_im_reg;
    assign out_x_re   = x_re_reg;
    assign out_x_im   = x_im_reg;

endmodule

// ===== src/cau_out.sv =====
// ----------------------------------------------------------------------------
// cau_out
// Quotient clamping, result packing and output register with skid stage.
// ----------------------------------------------------------------------------
module cau_out #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int NB        = 2 * WORD_BITS + 1 + cau_pkg::FRAC_BITS_DEF,
    parameter int OUT_BITS  = ((2 * WORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  cau_pkg::cau_ctrl_t in_ctrl,
    input  logic [NB-1:0]      in_x_re,
    input  logic [NB-1:0]      in_x_im,
    output logic               en,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_BITS-1:0] m_tdata
);

    localparam int W = WORD_BITS;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

    logic [NB-W:0]  hi_re, hi_im;
    logic           ovf_re, ovf_im;
    logic [W-1:0]   res_re, res_im, q_re, q_im;
    logic           sat;
    logic [OUT_BITS-1:0] word;

    always_comb
    begin
        hi_re = in_x_re[NB-1:W-1];
        hi_im = in_x_im[NB-1:W-1];
        if (in_ctrl.neg_re)
        begin
            ovf_re = (|hi_re[NB-W:1]) || (hi_re[0] && (|in_x_re[W-2:0]));
            q_re = ovf_re ? MINW : (-in_x_re[W-1:0]);
        end
        else
        begin
            ovf_re = |hi_re;
            q_re = ovf_re ? MAXW : in_x_re[W-1:0];
        end
        if (in_ctrl.neg_im)
        begin
            ovf_im = (|hi_im[NB-W:1]) || (hi_im[0] && (|in_x_im[W-2:0]));
            q_im = ovf_im ? MINW : (-in_x_im[W-1:0]);
        end
        else
        begin
            ovf_im = |hi_im;
            q_im = ovf_im ? MAXW : in_x_im[W-1:0];
        end
        if (in_ctrl.is_div)
        begin
            res_re = in_ctrl.dz ? '0 : q_re;
            res_im = in_ctrl.dz ? '0 : q_im;
            sat = !in_ctrl.dz && (ovf_re || ovf_im);
        end
        else
        begin
            res_re = in_x_re[W-1:0];
            res_im = in_x_im[W-1:0];
            sat = in_ctrl.sat;
        end
        word = OUT_BITS'({sat, in_ctrl.dz, in_ctrl.cmp, res_im, res_re});
    end

    logic                out_valid_reg, skid_valid_reg;
    logic [OUT_BITS-1:0] out_data_reg, skid_data_reg;
    logic                push;

    assign en   = !skid_valid_reg;
    assign push = in_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : word;
        end
        else if (push)
        begin
            skid_data_reg <= word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex add, subtract, multiply, divide and compare on signed fixed point.
// ----------------------------------------------------------------------------
// timing: identical for every func; each item passes the same stages and division cells
// throughput: one transaction per cycle while the output skid stage is empty; a full
//   skid stage stalls the front and the chain of division cells, one quotient bit per cell
// reset: asynchronous, clears all valid bits; no item is kept across reset
// ----------------------------------------------------------------------------
module complex_arith_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
    parameter int IN_BITS   = ((cau_pkg::FUNC_BITS + 4 * WORD_BITS + 7) / 8) * 8,
    parameter int OUT_BITS  = ((2 * WORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // func, a_re, a_im, b_re, b_im
    input  logic [IN_BITS-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // res_re, res_im, compare_true, div_zero, saturated
    output logic [OUT_BITS-1:0] m_tdata
);

    localparam int W  = WORD_BITS;
    localparam int FB = cau_pkg::FUNC_BITS;
    localparam int PW = 2 * WORD_BITS;
    localparam int NB = 2 * WORD_BITS + 1 + FRAC_BITS;

    logic en;

    logic                 c_valid [NB+1];
    cau_pkg::cau_ctrl_t   c_ctrl  [NB+1];
    logic [PW-1:0]        c_den   [NB+1];
    logic [PW-1:0]        c_rre   [NB+1];
    logic [PW-1:0]        c_rim   [NB+1];
    logic [NB-1:0]        c_xre   [NB+1];
    logic [NB-1:0]        c_xim   [NB+1];

    assign s_tready = en;
    assign c_rre[0] = '0;
    assign c_rim[0] = '0;

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .NB        (NB)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .func      (s_tdata[FB-1:0]),
        .a_re      (s_tdata[FB+W-1:FB]),
        .a_im      (s_tdata[FB+2*W-1:FB+W]),
        .b_re      (s_tdata[FB+3*W-1:FB+2*W]),
        .b_im      (s_tdata[FB+4*W-1:FB+3*W]),
        .out_valid (c_valid[0]),
        .out_ctrl  (c_ctrl[0]),
        .out_den   (c_den[0]),
        .out_x_re  (c_xre[0]),
        .out_x_im  (c_xim[0])
    );

    for (genvar i = 0; i < NB; i++)
    begin : g_cell
        cau_div_cell #(
            .WORD_BITS (WORD_BITS),
            .NB        (NB)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .in_valid   (c_valid[i]),
            .in_ctrl    (c_ctrl[i]),
            .in_den     (c_den[i]),
            .in_rem_re  (c_rre[i]),
            .in_rem_im  (c_rim[i]),
            .in_x_re    (c_xre[i]),
            .in_x_im    (c_xim[i]),
            .out_valid  (c_valid[i+1]),
            .out_ctrl   (c_ctrl[i+1]),
            .out_den    (c_den[i+1]),
            .out_rem_re (c_rre[i+1]),
            .out_rem_im (c_rim[i+1]),
            .out_x_re   (c_xre[i+1]),
            .out_x_im   (c_xim[i+1])
        );
    end

    cau_out #(
        .WORD_BITS (WORD_BITS),
        .NB        (NB),
        .OUT_BITS  (OUT_BITS)
    ) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_valid[NB]),
        .in_ctrl  (c_ctrl[NB]),
        .in_x_re  (c_xre[NB]),
        .in_x_im  (c_xim[NB]),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/cau_checker.sv =====
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the result stream of the complex arithmetic unit.
// ----------------------------------------------------------------------------
module cau_checker #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int OUT_BITS  = ((2 * WORD_BITS + 3 + 7) / 8) * 8
) (
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OUT_BITS-1:0] m_tdata
);

    localparam int W = WORD_BITS;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*W+1] |->
            m_tdata[2*W-1:0] == '0 && !m_tdata[2*W+2] && !m_tdata[2*W])
        else $error("divide by zero result not clean");

    a_compare: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2*W] |-> m_tdata[2*W-1:0] == '0 && !m_tdata[2*W+2])
        else $error("compare result carries data");

endmodule

bind complex_arith_unit cau_checker #(
    .WORD_BITS (WORD_BITS),
    .OUT_BITS  (OUT_BITS)
) u_cau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
